>>> sv/hnm_pkg.sv
// shared types and constants for the http header name matcher
// no dependencies; used by the result and config interfaces and every module of the block
`timescale 1ns / 1ps

package hnm_pkg;

	// sizes
	localparam int MaxNameBytes = 32;
	localparam int OffsetBits   = 16;
	localparam int LenBits      = 6;
	localparam int CfgIndexBits = 3;
	localparam int CfgDataBits  = 64;
	localparam int NameWords    = 4;

	// character codes
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChLf    = 8'h0A;

	// configuration register indexes
	typedef enum logic [CfgIndexBits-1:0] {
		REG_NAME_LENGTH       = 3'd0,
		REG_NAME_BYTES_LOW    = 3'd1,
		REG_NAME_BYTES_MID_LO = 3'd2,
		REG_NAME_BYTES_MID_HI = 3'd3,
		REG_NAME_BYTES_HIGH   = 3'd4
	} reg_index_t;

	// line scanning phase
	typedef enum logic [1:0] {
		PHASE_SKIP = 2'd0,
		PHASE_LINE = 2'd1
	} phase_t;

	// configuration seen by the scanner
	typedef struct packed {
		logic [LenBits-1:0]               used_length;
		logic [MaxNameBytes-1:0][7:0]     name_bytes;
	} cfg_t;

	// per-message scanning state
	typedef struct packed {
		logic [OffsetBits-1:0] byte_position;
		phase_t                line_phase;
		logic                  held_cr;
		logic [LenBits-1:0]    line_length;
		logic                  prefix_ok;
		logic                  colon_seen;
		logic                  colon_valid;
		logic [OffsetBits-1:0] colon_offset;
		logic                  pending_match;
		logic                  message_done;
	} scan_state_t;

	// result of one byte step
	typedef struct packed {
		logic                  emit;
		logic                  found;
		logic [OffsetBits-1:0] value_offset;
	} step_result_t;

	localparam scan_state_t ScanReset = '{
		byte_position: '0,
		line_phase:    PHASE_SKIP,
		held_cr:       1'b0,
		line_length:   '0,
		prefix_ok:     1'b1,
		colon_seen:    1'b0,
		colon_valid:   1'b0,
		colon_offset:  '0,
		pending_match: 1'b0,
		message_done:  1'b0
	};

endpackage

>>> sv/hnm_byte_if.sv
// message byte channel: valid/ready with one byte and its end mark
// no dependencies
`timescale 1ns / 1ps

interface hnm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

>>> sv/hnm_result_if.sv
// result channel: valid/ready with found flag and value offset
// depends on hnm_pkg
`timescale 1ns / 1ps

interface hnm_result_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [hnm_pkg::OffsetBits-1:0] value_offset;

	modport source (output valid, output found, output value_offset, input ready);
	modport sink   (input valid, input found, input value_offset, output ready);
endinterface

>>> sv/hnm_cfg_if.sv
// configuration write channel: valid/ready with register index and data
// depends on hnm_pkg
`timescale 1ns / 1ps

interface hnm_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [hnm_pkg::CfgIndexBits-1:0] index;
	logic [hnm_pkg::CfgDataBits-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/hnm_cfg_regs.sv
// configuration registers: name length and the 32 name bytes
// depends on hnm_pkg and hnm_cfg_if
`timescale 1ns / 1ps

module hnm_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	hnm_cfg_if.sink          cfg,
	output hnm_pkg::cfg_t    cfg_out
);

	localparam logic [hnm_pkg::LenBits-1:0] MaxLen = hnm_pkg::LenBits'(hnm_pkg::MaxNameBytes);

	logic [hnm_pkg::LenBits-1:0]                           name_length_q;
	logic [hnm_pkg::NameWords-1:0][hnm_pkg::CfgDataBits-1:0] name_words_q;
	logic                                                  wr_beat;

	assign cfg.ready = 1'b1;
	assign wr_beat   = cfg.valid & cfg.ready;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_length_q <= '0;
			name_words_q  <= '0;
		end else if (wr_beat) begin
			case (hnm_pkg::reg_index_t'(cfg.index))
				hnm_pkg::REG_NAME_LENGTH:       name_length_q   <= cfg.data[hnm_pkg::LenBits-1:0];
				hnm_pkg::REG_NAME_BYTES_LOW:    name_words_q[0] <= cfg.data;
				hnm_pkg::REG_NAME_BYTES_MID_LO: name_words_q[1] <= cfg.data;
				hnm_pkg::REG_NAME_BYTES_MID_HI: name_words_q[2] <= cfg.data;
				hnm_pkg::REG_NAME_BYTES_HIGH:   name_words_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// clamp the compare length to the name storage
	always_comb begin
		cfg_out.used_length = (name_length_q > MaxLen) ? MaxLen : name_length_q;
		cfg_out.name_bytes  = name_words_q;
	end

endmodule

>>> sv/hnm_scan.sv
// per-byte line scanner: line splitting, prefix compare and colon tracking
// depends on hnm_pkg
`timescale 1ns / 1ps

module hnm_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            data_byte,
	input  logic                  is_last,
	input  hnm_pkg::cfg_t         cfg,
	output hnm_pkg::step_result_t result
);

	localparam logic [hnm_pkg::LenBits-1:0] LenSat =
		hnm_pkg::LenBits'(hnm_pkg::MaxNameBytes + 1);
	localparam logic [hnm_pkg::OffsetBits-1:0] OffOne = hnm_pkg::OffsetBits'(1);

	hnm_pkg::scan_state_t state_q;
	hnm_pkg::scan_state_t state_d;

	function automatic hnm_pkg::scan_state_t clear_line(input hnm_pkg::scan_state_t s);
		hnm_pkg::scan_state_t r;
		r             = s;
		r.line_length = '0;
		r.prefix_ok   = 1'b1;
		r.colon_seen  = 1'b0;
		r.colon_valid = 1'b0;
		r.colon_offset = '0;
		r.held_cr     = 1'b0;
		return r;
	endfunction

	// one content byte of a line
	function automatic hnm_pkg::scan_state_t take_content(
		input hnm_pkg::scan_state_t      s,
		input logic [7:0]                ch,
		input logic [hnm_pkg::OffsetBits-1:0] pos,
		input hnm_pkg::cfg_t             c
	);
		hnm_pkg::scan_state_t r;
		logic                 in_name;
		r       = s;
		in_name = s.line_length < c.used_length;
		if (in_name && ch != c.name_bytes[s.line_length[4:0]])
			r.prefix_ok = 1'b0;
		if (!s.colon_seen) begin
			if (ch == hnm_pkg::ChColon) begin
				r.colon_seen   = 1'b1;
				r.colon_offset = pos + OffOne;
				if (in_name)
					r.prefix_ok = 1'b0;
			end
		end else begin
			r.colon_valid = 1'b1;
		end
		if (s.line_length < LenSat)
			r.line_length = s.line_length + 1'b1;
		return r;
	endfunction

	// next state and result for the byte in hand
	always_comb begin
		hnm_pkg::scan_state_t w;
		logic [hnm_pkg::OffsetBits-1:0] pos;
		pos     = state_q.byte_position;
		w       = state_q;
		state_d = state_q;
		result  = '0;
		if (state_q.message_done) begin
			if (is_last)
				state_d = hnm_pkg::ScanReset;
		end else if (state_q.pending_match) begin
			result.emit         = 1'b1;
			result.found        = 1'b1;
			result.value_offset = state_q.colon_offset;
			if (is_last)
				state_d = hnm_pkg::ScanReset;
			else
				state_d.message_done = 1'b1;
		end else if (state_q.line_phase == hnm_pkg::PHASE_SKIP &&
			(data_byte == hnm_pkg::ChCr || data_byte == hnm_pkg::ChLf)) begin
			// line breaks ahead of a line
			if (is_last) begin
				state_d     = hnm_pkg::ScanReset;
				result.emit = 1'b1;
			end else begin
				state_d.byte_position = pos + OffOne;
			end
		end else begin
			if (state_q.line_phase == hnm_pkg::PHASE_SKIP) begin
				w            = clear_line(state_q);
				w.line_phase = hnm_pkg::PHASE_LINE;
			end
			if (w.held_cr && data_byte == hnm_pkg::ChLf) begin
				// end of line
				w.held_cr = 1'b0;
				if (w.colon_valid && w.prefix_ok) begin
					w.pending_match = 1'b1;
				end else begin
					w            = clear_line(w);
					w.line_phase = hnm_pkg::PHASE_SKIP;
				end
			end else begin
				// held cr turns out to be content
				if (w.held_cr) begin
					w         = take_content(w, hnm_pkg::ChCr, pos - OffOne, cfg);
					w.held_cr = 1'b0;
				end
				if (data_byte == hnm_pkg::ChCr)
					w.held_cr = 1'b1;
				else
					w = take_content(w, data_byte, pos, cfg);
			end
			w.byte_position = pos + OffOne;
			if (is_last) begin
				state_d     = hnm_pkg::ScanReset;
				result.emit = 1'b1;
			end else begin
				state_d = w;
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hnm_pkg::ScanReset;
		else if (advance)
			state_q <= state_d;
	end

endmodule

>>> sv/http_header_name_matcher.sv
// http header name matcher: finds the first header line starting with a set name
// an accepted byte beat is held in the input register, and the scanner's result for it goes to the result register
// throughput: one byte per cycle, limited only by the result channel ready
// reset (arst_n low): config registers clear to zero, scanner starts a new message
// depends on hnm_pkg, the three channel interfaces, hnm_cfg_regs and hnm_scan
`timescale 1ns / 1ps

module http_header_name_matcher (
	input  logic          clk,
	input  logic          arst_n,
	hnm_byte_if.sink      msg,
	hnm_result_if.source  result,
	hnm_cfg_if.sink       cfg
);

	hnm_pkg::cfg_t         cfg_cur;
	hnm_pkg::step_result_t step;

	logic                           valid_s1;
	logic [7:0]                     data_byte_s1;
	logic                           is_last_s1;
	logic                           out_valid_q;
	logic                           found_q;
	logic [hnm_pkg::OffsetBits-1:0] value_offset_q;
	logic                           advance;

	// byte moves from the input register once the result slot is free
	assign advance   = valid_s1 & (~out_valid_q | result.ready);
	assign msg.ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (msg.ready)
			valid_s1 <= msg.valid;
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			data_byte_s1 <= msg.data_byte;
			is_last_s1   <= msg.is_last;
		end
	end

	hnm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_cur)
	);

	hnm_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (data_byte_s1),
		.is_last   (is_last_s1),
		.cfg       (cfg_cur),
		.result    (step)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= step.emit;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && step.emit) begin
			found_q        <= step.found;
			value_offset_q <= step.value_offset;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.found        = found_q;
	assign result.value_offset = value_offset_q;

endmodule

>>> bench/testbench.sv
// testbench for http_header_name_matcher: byte beats in, lookup results checked on the fly
// depends on hnm_pkg, hnm_byte_if, hnm_result_if, hnm_cfg_if and the matcher rtl
`timescale 1ns / 1ps

module testbench;

	typedef logic [7:0] byte_t;

	// one expected lookup result
	typedef struct packed {
		logic                           found;
		logic [hnm_pkg::OffsetBits-1:0] offset;
	} lookup_t;

	// byte budget of each random traffic phase
	localparam int PhaseBytes = 50;

	logic clk;
	logic arst_n;

	hnm_byte_if   msg_if ();
	hnm_result_if res_if ();
	hnm_cfg_if    cfg_if ();

	http_header_name_matcher uut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	int send_idle_pct;
	int stall_pct;
	int errors;
	int sent_bytes;

	lookup_t lookup_q[$];

	// name as the stimulus side sees it
	byte_t gen_name [hnm_pkg::MaxNameBytes];
	int    gen_len;

	// mirror of the block's registers and scanner
	logic [hnm_pkg::LenBits-1:0]     mirror_len;
	logic [hnm_pkg::CfgDataBits-1:0] mirror_name [hnm_pkg::NameWords];
	hnm_pkg::scan_state_t            ss;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 50)
			$display("%0t: %s", $time, what);
	endtask

	// ---------------------------------------------------------------
	// scanner prediction
	// ---------------------------------------------------------------

	function automatic int used_length();
		return (mirror_len > hnm_pkg::MaxNameBytes) ? hnm_pkg::MaxNameBytes : int'(mirror_len);
	endfunction

	function automatic byte_t name_at(input int k);
		return mirror_name[k / 8][(k % 8) * 8 +: 8];
	endfunction

	function automatic void clear_line();
		ss.line_length = '0;
		ss.prefix_ok   = 1'b1;
		ss.colon_seen  = 1'b0;
		ss.colon_valid = 1'b0;
		ss.colon_offset = '0;
		ss.held_cr     = 1'b0;
	endfunction

	function automatic void restart_scan();
		ss = hnm_pkg::ScanReset;
	endfunction

	// one content byte of a line: prefix compare and colon tracking
	function automatic void take_content(input byte_t c,
		input logic [hnm_pkg::OffsetBits-1:0] p);
		int idx = int'(ss.line_length);
		int n   = used_length();
		if (idx < n && c != name_at(idx))
			ss.prefix_ok = 1'b0;
		if (!ss.colon_seen) begin
			if (c == hnm_pkg::ChColon) begin
				ss.colon_seen   = 1'b1;
				ss.colon_offset = p + 1'b1;
				if (idx < n)
					ss.prefix_ok = 1'b0;
			end
		end else begin
			ss.colon_valid = 1'b1;
		end
		if (ss.line_length < hnm_pkg::MaxNameBytes + 1)
			ss.line_length = ss.line_length + 1'b1;
	endfunction

	// advance the mirror by one byte; returns 1 when a lookup result is due
	function automatic bit scan_byte(input byte_t c, input bit last, output lookup_t res);
		logic [hnm_pkg::OffsetBits-1:0] off;
		res = '{found: 1'b0, offset: '0};
		if (ss.message_done) begin
			if (last)
				restart_scan();
			return 1'b0;
		end
		if (ss.pending_match) begin
			off = ss.colon_offset;
			if (last)
				restart_scan();
			else
				ss.message_done = 1'b1;
			res = '{found: 1'b1, offset: off};
			return 1'b1;
		end
		if (ss.line_phase == hnm_pkg::PHASE_SKIP) begin
			if (c == hnm_pkg::ChCr || c == hnm_pkg::ChLf) begin
				if (last) begin
					restart_scan();
					return 1'b1;
				end
				ss.byte_position = ss.byte_position + 1'b1;
				return 1'b0;
			end
			ss.line_phase = hnm_pkg::PHASE_LINE;
			clear_line();
		end
		// cr lf closes the line
		if (ss.held_cr && c == hnm_pkg::ChLf) begin
			ss.held_cr = 1'b0;
			if (last) begin
				restart_scan();
				return 1'b1;
			end
			if (ss.colon_valid && ss.prefix_ok) begin
				ss.pending_match = 1'b1;
			end else begin
				ss.line_phase = hnm_pkg::PHASE_SKIP;
				clear_line();
			end
			ss.byte_position = ss.byte_position + 1'b1;
			return 1'b0;
		end
		// a held cr not followed by lf is plain content
		if (ss.held_cr) begin
			ss.held_cr = 1'b0;
			take_content(hnm_pkg::ChCr, ss.byte_position - 1'b1);
		end
		if (c == hnm_pkg::ChCr)
			ss.held_cr = 1'b1;
		else
			take_content(c, ss.byte_position);
		if (last) begin
			restart_scan();
			return 1'b1;
		end
		ss.byte_position = ss.byte_position + 1'b1;
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------
	// monitor: config beats, byte beats and result checks
	// ---------------------------------------------------------------

	always @(posedge clk) begin : monitor
		lookup_t predicted;
		lookup_t want;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (hnm_pkg::reg_index_t'(cfg_if.index))
					hnm_pkg::REG_NAME_LENGTH:
						mirror_len = cfg_if.data[hnm_pkg::LenBits-1:0];
					hnm_pkg::REG_NAME_BYTES_LOW:    mirror_name[0] = cfg_if.data;
					hnm_pkg::REG_NAME_BYTES_MID_LO: mirror_name[1] = cfg_if.data;
					hnm_pkg::REG_NAME_BYTES_MID_HI: mirror_name[2] = cfg_if.data;
					hnm_pkg::REG_NAME_BYTES_HIGH:   mirror_name[3] = cfg_if.data;
					default: ;
				endcase
			end
			if (msg_if.valid && msg_if.ready) begin
				if (scan_byte(msg_if.data_byte, msg_if.is_last, predicted))
					lookup_q.push_back(predicted);
			end
			if (res_if.valid && res_if.ready) begin
				if (lookup_q.size() == 0) begin
					report_mismatch("result beat with no lookup outstanding");
				end else begin
					want = lookup_q.pop_front();
					if (res_if.found !== want.found)
						report_mismatch($sformatf("found %b, expected %b",
							res_if.found, want.found));
					if (res_if.value_offset !== want.offset)
						report_mismatch($sformatf("value_offset %0d, expected %0d",
							res_if.value_offset, want.offset));
				end
			end
		end
	end

	// result side back-pressure
	always @(posedge clk)
		res_if.ready <= ($urandom_range(99) >= stall_pct);

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	task automatic send_byte(input byte_t b, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_if.valid <= 1'b0;
			@(posedge clk);
		end
		msg_if.valid     <= 1'b1;
		msg_if.data_byte <= b;
		msg_if.is_last   <= last;
		@(posedge clk);
		while (!msg_if.ready)
			@(posedge clk);
		sent_bytes++;
	endtask

	task automatic send_message(input byte_t m[$]);
		for (int i = 0; i < m.size(); i++)
			send_byte(m[i], i == m.size() - 1);
	endtask

	// drain: every lookup back, then let trailing bytes settle
	task automatic wait_idle();
		msg_if.valid <= 1'b0;
		@(posedge clk);
		while (lookup_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// write length and all four name words from gen_name
	task automatic load_name(input logic [hnm_pkg::LenBits-1:0] len);
		logic [hnm_pkg::CfgDataBits-1:0] word;
		gen_len = len;
		cfg_if.valid <= 1'b1;
		cfg_if.index <= hnm_pkg::REG_NAME_LENGTH;
		cfg_if.data  <= hnm_pkg::CfgDataBits'(len);
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		for (int w = 0; w < hnm_pkg::NameWords; w++) begin
			for (int b = 0; b < 8; b++)
				word[b * 8 +: 8] = gen_name[w * 8 + b];
			cfg_if.index <= hnm_pkg::reg_index_t'(hnm_pkg::REG_NAME_BYTES_LOW + w);
			cfg_if.data  <= word;
			@(posedge clk);
			while (!cfg_if.ready)
				@(posedge clk);
		end
		cfg_if.valid <= 1'b0;
	endtask

	function automatic void fill_name(input string s, input byte_t pad);
		for (int k = 0; k < hnm_pkg::MaxNameBytes; k++)
			gen_name[k] = (k < s.len()) ? byte_t'(s[k]) : pad;
	endfunction

	// text with ^ standing for cr and ~ for lf
	function automatic void put_text(ref byte_t q[$], input string s);
		for (int i = 0; i < s.len(); i++)
			case (s[i])
				"^":     q.push_back(hnm_pkg::ChCr);
				"~":     q.push_back(hnm_pkg::ChLf);
				default: q.push_back(s[i]);
			endcase
	endfunction

	task automatic send_text(input string s);
		byte_t q[$];
		put_text(q, s);
		send_message(q);
	endtask

	// a run of one byte value followed by text
	task automatic send_run(input byte_t b, input int count, input string tail);
		byte_t q[$];
		repeat (count) q.push_back(b);
		put_text(q, tail);
		send_message(q);
	endtask

	function automatic byte_t plain_byte();
		byte_t b = byte_t'($urandom_range(255));
		if (b == hnm_pkg::ChColon || b == hnm_pkg::ChCr || b == hnm_pkg::ChLf)
			b = "A";
		return b;
	endfunction

	// mostly well-formed header lines around the current name, some noise
	function automatic void build_random_message(ref byte_t q[$]);
		int n = (gen_len > hnm_pkg::MaxNameBytes) ? hnm_pkg::MaxNameBytes : gen_len;
		int kind;
		int cut;
		if ($urandom_range(99) < 30)
			repeat ($urandom_range(1, 3))
				q.push_back($urandom_range(1) ? hnm_pkg::ChCr : hnm_pkg::ChLf);
		repeat ($urandom_range(1, 4)) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				// name line: match, near miss, or empty value
				for (int k = 0; k < n; k++)
					q.push_back(gen_name[k]);
				if (kind >= 40 && n > 0) begin
					cut = q.size() - n + $urandom_range(n - 1);
					q[cut] = q[cut] ^ byte_t'(1 << $urandom_range(7));
				end
				repeat ($urandom_range(0, 3)) q.push_back(plain_byte());
				q.push_back(hnm_pkg::ChColon);
				if (kind < 50)
					repeat ($urandom_range(1, 4)) q.push_back(byte_t'($urandom_range(255)));
			end else if (kind < 70) begin
				// no colon at all
				repeat ($urandom_range(1, 6)) q.push_back(plain_byte());
			end else if (kind < 80) begin
				// colon inside the name
				cut = (n > 0) ? $urandom_range(n - 1) : 0;
				for (int k = 0; k < cut; k++)
					q.push_back(gen_name[k]);
				q.push_back(hnm_pkg::ChColon);
				repeat ($urandom_range(1, 3)) q.push_back(plain_byte());
			end else begin
				repeat ($urandom_range(1, 8)) q.push_back(byte_t'($urandom_range(255)));
			end
			q.push_back(hnm_pkg::ChCr);
			q.push_back(hnm_pkg::ChLf);
		end
		// trailing bytes make the last line count; without them its closing lf is the last byte and no match is reported
		if ($urandom_range(99) < 80)
			repeat ($urandom_range(1, 3)) q.push_back(byte_t'($urandom_range(255)));
	endfunction

	task automatic randomize_name();
		int r = $urandom_range(99);
		for (int k = 0; k < hnm_pkg::MaxNameBytes; k++)
			gen_name[k] = plain_byte();
		if (r < 60)
			load_name(hnm_pkg::LenBits'($urandom_range(0, 6)));
		else if (r < 88)
			load_name(hnm_pkg::LenBits'($urandom_range(7, 32)));
		else
			load_name(hnm_pkg::LenBits'($urandom_range(33, 63)));
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset config: zero name length, any valid colon line matches
	task automatic test_reset_defaults();
		send_text("a:b^~c");
		send_text(":^~x");
	endtask

	task automatic test_line_breaks();
		wait_idle();
		fill_name("Host", 8'h00);
		load_name(4);
		send_text("^~~^Host:v^~X");
		send_text("Host:v^~");
		send_text("^~");
		send_text("^");
		send_text("Hostname^~Host:a^~X");
		send_text("Host:x^~More");
		send_text("Host:x^~Y");
	endtask

	task automatic test_special_cases();
		send_text("Hos^t:v^~X");
		send_text("Host:^v^~X");
		send_text("Host:^^~X");
		send_text("Host:^~X");
		send_text("Hos:x^~X");
		send_text("host:x^~X");
		send_text("Host-Name: y^~X");
	endtask

	// full-width names, all-ones and all-zero words, oversized length
	task automatic test_name_extremes();
		wait_idle();
		fill_name("", 8'hFF);
		load_name(32);
		send_run(8'hFF, 32, ":v^~Z");
		send_run(8'hFF, 31, "~:v^~Z");
		wait_idle();
		fill_name("", 8'h00);
		load_name(63);
		send_run(8'h00, 32, ":v^~x");
		send_run(8'h00, 31, ":v^~x");
	endtask

	// a long first line pushes the reported offset past the low byte
	task automatic test_long_line();
		wait_idle();
		fill_name("Host", 8'h00);
		load_name(4);
		send_run("a", 250, "^~Host:v^~Z");
	endtask

	task automatic test_random_traffic();
		int    idle_set [4] = '{0, 70, 0, 6};
		int    stall_set[4] = '{0, 0, 70, 6};
		int    byte_mark;
		int    msgs;
		byte_t q[$];
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			send_idle_pct = idle_set[p];
			stall_pct     = stall_set[p];
			byte_mark     = sent_bytes;
			msgs          = 0;
			while (sent_bytes - byte_mark < PhaseBytes) begin
				if (msgs % 2 == 0) begin
					wait_idle();
					randomize_name();
				end
				q.delete();
				build_random_message(q);
				send_message(q);
				msgs++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		arst_n           = 1'b0;
		msg_if.valid     = 1'b0;
		msg_if.data_byte = '0;
		msg_if.is_last   = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = hnm_pkg::REG_NAME_LENGTH;
		cfg_if.data      = '0;
		send_idle_pct    = 0;
		stall_pct        = 0;
		errors           = 0;
		sent_bytes       = 0;
		gen_len          = 0;
		mirror_len       = '0;
		for (int w = 0; w < hnm_pkg::NameWords; w++)
			mirror_name[w] = '0;
		ss = hnm_pkg::ScanReset;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_line_breaks();
		test_special_cases();
		test_name_extremes();
		test_long_line();
		test_random_traffic();
		wait_idle();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
